// File: hw/rtl/msp_pkg.sv
package msp_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 5;
  localparam int CFG_AW = 1;

  localparam logic [CFG_AW-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_NUM_COLS = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

  localparam logic KIND_ROW_MIN = 1'b0;
  localparam logic KIND_ROW_MAX = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROW,
    ST_COL0,
    ST_COL1
  } st_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     kind;
    logic                     last;
  } res_t;

endpackage

// File: hw/rtl/msp_ram.sv
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/matrix_saddle_point_finder.sv
// Strict saddle point finder.
// Elements of a signed matrix arrive on the in_ channel in row-major order, one
// item per cycle while in_tready is high, and are written to an on-chip store.
// The matrix size comes from the cfg_ port (register 0 rows, 1 columns, zero
// read as one, large values clipped to the store size); writing either
// register restarts loading. The item that completes the matrix starts a scan
// of the store; no element is taken until it is finished. For each row the
// scan reads the row once to find a unique minimum and a unique maximum, then
// reads the column of each unique candidate and skips the column of one that
// is not unique. The length of the scan is bounded by the single read port of
// the store. Up to two results then go to a two-entry output queue: kind 0
// (row minimum, column maximum) first, then kind 1, or a single found = 0
// result; out_tlast marks the final one. Loading of the next matrix goes on
// while the queue drains; only its last element waits for an empty queue. A
// stalled receiver just holds the queue. After reset the size is 16 by 16,
// loading starts at row 0 and the queue is empty; the store itself is not
// cleared.
module matrix_saddle_point_finder #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // element_value
  input  logic [31:0]                in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // found, saddle_value, row_index, col_index, zero fill
  output logic [47:0]                out_tdata,
  // saddle_kind
  output logic                       out_tuser,
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_we,
  input  logic [msp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [msp_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIMW  = ($clog2(MAXD + 1) > msp_pkg::CFG_W) ? $clog2(MAXD + 1)
                                                              : msp_pkg::CFG_W;
  localparam int DW    = msp_pkg::DATA_W;
  localparam int IW    = msp_pkg::IDX_W;

  msp_pkg::st_t state_r, state_nxt;

  logic [msp_pkg::CFG_W-1:0] num_rows_r, num_cols_r;
  logic [DIMW-1:0] rows_eff, cols_eff, lim;

  logic [DIMW-1:0] ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic [DIMW-1:0] sc_row_r, sc_row_nxt;
  logic [DIMW-1:0] k_r, k_nxt, j;

  logic signed [DW-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [DIMW-1:0]      minc_r, minc_nxt, maxc_r, maxc_nxt;
  logic                 minu_r, minu_nxt, maxu_r, maxu_nxt;
  logic                 ok_r, ok_nxt;

  logic                 f0_r, f0_nxt, f1_r, f1_nxt;
  logic signed [DW-1:0] f0v_r, f0v_nxt, f1v_r, f1v_nxt;
  logic [IW-1:0]        f0row_r, f0row_nxt, f0col_r, f0col_nxt;
  logic [IW-1:0]        f1row_r, f1row_nxt, f1col_r, f1col_nxt;

  msp_pkg::res_t q0_r, q0_nxt, q1_r, q1_nxt, r0, r1;
  logic [1:0]    q_cnt_r, q_cnt_nxt;

  logic in_acc, out_acc, last_elem, scanning, skip, done, proc, last_row;
  logic rec0, rec1, fill;

  logic [AW-1:0]        waddr, raddr;
  logic [DIMW-1:0]      rd_row, rd_col;
  logic [DW-1:0]        rdata;
  logic signed [DW-1:0] v;

  // effective sizes
  always_comb begin
    if (num_rows_r == '0) begin
      rows_eff = DIMW'(1);
    end else if (DIMW'(num_rows_r) > DIMW'(MAX_ROWS)) begin
      rows_eff = DIMW'(MAX_ROWS);
    end else begin
      rows_eff = DIMW'(num_rows_r);
    end
    if (num_cols_r == '0) begin
      cols_eff = DIMW'(1);
    end else if (DIMW'(num_cols_r) > DIMW'(MAX_COLS)) begin
      cols_eff = DIMW'(MAX_COLS);
    end else begin
      cols_eff = DIMW'(num_cols_r);
    end
  end

  assign last_elem = (ld_col_r == cols_eff - DIMW'(1)) && (ld_row_r == rows_eff - DIMW'(1));
  assign in_tready = (state_r == msp_pkg::ST_LOAD) && !(last_elem && q_cnt_r != 2'd0);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  assign scanning = (state_r != msp_pkg::ST_LOAD);
  assign lim      = (state_r == msp_pkg::ST_ROW) ? cols_eff : rows_eff;
  assign skip     = ((state_r == msp_pkg::ST_COL0) && !minu_r) ||
                    ((state_r == msp_pkg::ST_COL1) && !maxu_r);
  assign done     = scanning && (skip || k_r == lim);
  assign proc     = scanning && !skip && (k_r != '0);
  assign j        = k_r - DIMW'(1);
  assign last_row = (sc_row_r == rows_eff - DIMW'(1));
  assign v        = rdata;

  // store address of the next read
  always_comb begin
    case (state_r)
      msp_pkg::ST_ROW: begin
        rd_row = sc_row_r;
        rd_col = k_r;
      end
      msp_pkg::ST_COL0: begin
        rd_row = k_r;
        rd_col = minc_r;
      end
      msp_pkg::ST_COL1: begin
        rd_row = k_r;
        rd_col = maxc_r;
      end
      default: begin
        rd_row = '0;
        rd_col = '0;
      end
    endcase
  end

  assign raddr = AW'(rd_row) * AW'(MAX_COLS) + AW'(rd_col);
  assign waddr = AW'(ld_row_r) * AW'(MAX_COLS) + AW'(ld_col_r);

  msp_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (in_acc),
    .waddr(waddr),
    .wdata(in_tdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msp_pkg::ST_LOAD: begin
        if (in_acc && last_elem) begin
          state_nxt = msp_pkg::ST_ROW;
        end
      end
      msp_pkg::ST_ROW: begin
        if (done) begin
          state_nxt = msp_pkg::ST_COL0;
        end
      end
      msp_pkg::ST_COL0: begin
        if (done) begin
          state_nxt = msp_pkg::ST_COL1;
        end
      end
      msp_pkg::ST_COL1: begin
        if (done) begin
          state_nxt = last_row ? msp_pkg::ST_LOAD : msp_pkg::ST_ROW;
        end
      end
      default: begin
        state_nxt = msp_pkg::ST_LOAD;
      end
    endcase
  end

  // datapath and output queue
  always_comb begin
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    sc_row_nxt = sc_row_r;
    k_nxt      = k_r;
    min_nxt    = min_r;
    minc_nxt   = minc_r;
    minu_nxt   = minu_r;
    max_nxt    = max_r;
    maxc_nxt   = maxc_r;
    maxu_nxt   = maxu_r;
    ok_nxt     = ok_r;
    f0_nxt     = f0_r;
    f0v_nxt    = f0v_r;
    f0row_nxt  = f0row_r;
    f0col_nxt  = f0col_r;
    f1_nxt     = f1_r;
    f1v_nxt    = f1v_r;
    f1row_nxt  = f1row_r;
    f1col_nxt  = f1col_r;
    q0_nxt     = q0_r;
    q1_nxt     = q1_r;
    q_cnt_nxt  = q_cnt_r;
    r0         = '0;
    r1         = '0;

    if (cfg_we) begin
      ld_row_nxt = '0;
      ld_col_nxt = '0;
    end else if (in_acc) begin
      if (ld_col_r == cols_eff - DIMW'(1)) begin
        ld_col_nxt = '0;
        ld_row_nxt = last_elem ? '0 : ld_row_r + DIMW'(1);
      end else begin
        ld_col_nxt = ld_col_r + DIMW'(1);
      end
    end

    if (in_acc && last_elem) begin
      sc_row_nxt = '0;
      k_nxt      = '0;
      f0_nxt     = 1'b0;
      f1_nxt     = 1'b0;
    end

    if (scanning) begin
      k_nxt = done ? '0 : k_r + DIMW'(1);
      if (done && state_r == msp_pkg::ST_COL1 && !last_row) begin
        sc_row_nxt = sc_row_r + DIMW'(1);
      end
    end

    if (scanning && k_r == '0) begin
      ok_nxt = 1'b1;
    end

    if (proc) begin
      case (state_r)
        msp_pkg::ST_ROW: begin
          if (j == '0 || v < min_r) begin
            min_nxt  = v;
            minc_nxt = j;
            minu_nxt = 1'b1;
          end else if (v == min_r) begin
            minu_nxt = 1'b0;
          end
          if (j == '0 || v > max_r) begin
            max_nxt  = v;
            maxc_nxt = j;
            maxu_nxt = 1'b1;
          end else if (v == max_r) begin
            maxu_nxt = 1'b0;
          end
        end
        msp_pkg::ST_COL0: begin
          ok_nxt = ok_r && ((j == sc_row_r) || (v < min_r));
        end
        msp_pkg::ST_COL1: begin
          ok_nxt = ok_r && ((j == sc_row_r) || (v > max_r));
        end
        default: begin
          ok_nxt = ok_r;
        end
      endcase
    end

    rec0 = (state_r == msp_pkg::ST_COL0) && !skip && (k_r == lim) && ok_nxt;
    rec1 = (state_r == msp_pkg::ST_COL1) && !skip && (k_r == lim) && ok_nxt;
    fill = (state_r == msp_pkg::ST_COL1) && done && last_row;

    if (rec0) begin
      f0_nxt    = 1'b1;
      f0v_nxt   = min_r;
      f0row_nxt = IW'(sc_row_r);
      f0col_nxt = IW'(minc_r);
    end
    if (rec1) begin
      f1_nxt    = 1'b1;
      f1v_nxt   = max_r;
      f1row_nxt = IW'(sc_row_r);
      f1col_nxt = IW'(maxc_r);
    end

    // queue is empty for the whole scan, so fill and pop never meet
    if (fill) begin
      r0.found = f0_r;
      r0.value = f0v_r;
      r0.row   = f0row_r;
      r0.col   = f0col_r;
      r0.kind  = msp_pkg::KIND_ROW_MIN;
      r1.found = f1_nxt;
      r1.value = f1v_nxt;
      r1.row   = f1row_nxt;
      r1.col   = f1col_nxt;
      r1.kind  = msp_pkg::KIND_ROW_MAX;
      r1.last  = 1'b1;
      if (f0_r && f1_nxt) begin
        q0_nxt    = r0;
        q1_nxt    = r1;
        q_cnt_nxt = 2'd2;
      end else if (f0_r) begin
        r0.last   = 1'b1;
        q0_nxt    = r0;
        q_cnt_nxt = 2'd1;
      end else if (f1_nxt) begin
        q0_nxt    = r1;
        q_cnt_nxt = 2'd1;
      end else begin
        q0_nxt      = '0;
        q0_nxt.last = 1'b1;
        q_cnt_nxt   = 2'd1;
      end
    end else if (out_acc) begin
      q0_nxt    = q1_r;
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= msp_pkg::ST_LOAD;
      num_rows_r <= msp_pkg::SIZE_RESET;
      num_cols_r <= msp_pkg::SIZE_RESET;
      ld_row_r   <= '0;
      ld_col_r   <= '0;
      sc_row_r   <= '0;
      k_r        <= '0;
      minu_r     <= 1'b0;
      maxu_r     <= 1'b0;
      ok_r       <= 1'b0;
      f0_r       <= 1'b0;
      f1_r       <= 1'b0;
      q_cnt_r    <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
      sc_row_r <= sc_row_nxt;
      k_r      <= k_nxt;
      minu_r   <= minu_nxt;
      maxu_r   <= maxu_nxt;
      ok_r     <= ok_nxt;
      f0_r     <= f0_nxt;
      f1_r     <= f1_nxt;
      q_cnt_r  <= q_cnt_nxt;
      if (cfg_we && cfg_addr == msp_pkg::REG_NUM_ROWS) begin
        num_rows_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == msp_pkg::REG_NUM_COLS) begin
        num_cols_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    min_r   <= min_nxt;
    minc_r  <= minc_nxt;
    max_r   <= max_nxt;
    maxc_r  <= maxc_nxt;
    f0v_r   <= f0v_nxt;
    f0row_r <= f0row_nxt;
    f0col_r <= f0col_nxt;
    f1v_r   <= f1v_nxt;
    f1row_r <= f1row_nxt;
    f1col_r <= f1col_nxt;
    q0_r    <= q0_nxt;
    q1_r    <= q1_nxt;
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = {7'b0, q0_r.col, q0_r.row, q0_r.value, q0_r.found};
  assign out_tuser  = q0_r.kind;
  assign out_tlast  = q0_r.last;

`ifndef SYNTHESIS
  a_queue_idle_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r != 2'd0) |-> (state_r == msp_pkg::ST_LOAD))
    else $error("result queue holds items during a scan");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r != 2'd3))
    else $error("result queue overflow");

  a_queue_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2) |-> (!q0_r.last && q1_r.last && q0_r.found && q1_r.found))
    else $error("two queued results not ordered with final mark on the second");

  a_load_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_col_r < cols_eff) && (ld_row_r < rows_eff))
    else $error("load position outside the matrix");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    scanning |-> ((k_r <= lim) && (sc_row_r < rows_eff)))
    else $error("scan counter out of range");
`endif

endmodule

// File: verif/tb_matrix_saddle_point_finder.sv
`timescale 1ns / 100ps

module tb_matrix_saddle_point_finder;

  localparam int STORE_COLS     = msp_pkg::MAX_COLS_DEF;
  localparam int RANDOM_ITEMS   = 500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT    = 40;

  typedef enum int {
    FILL_SADDLE,
    FILL_NARROW,
    FILL_WIDE
  } fill_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic [31:0]                  in_tdata = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [47:0]                  out_tdata;
  logic                         out_tuser;
  logic                         out_tlast;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [msp_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [msp_pkg::CFG_W-1:0]    cfg_wdata = '0;

  // predictor state
  logic signed [31:0]           elem_store [0:255];
  logic [4:0]                   rows_cfg = msp_pkg::SIZE_RESET;
  logic [4:0]                   cols_cfg = msp_pkg::SIZE_RESET;
  int                           load_pos = 0;
  msp_pkg::res_t                saddle_q [$];

  logic signed [31:0]           grid [0:15][0:15];
  int                           items_sent = 0;
  int                           mismatches = 0;
  int                           idle_cycles = 0;
  int                           ready_hold = 0;
  int                           ready_roll;
  bit                           in_burst = 1'b0;

  matrix_saddle_point_finder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_size(input logic [4:0] raw);
    if (raw == 5'd0) return 1;
    if (raw > 5'd16) return 16;
    return int'(raw);
  endfunction

  // strict row min / column max (kind 0) or row max / column min (kind 1)
  function automatic bit find_saddle(input int rows, input int cols, input logic kind,
                                     output int fr, output int fc);
    logic signed [31:0] v;
    logic signed [31:0] o;
    bit ok;
    fr = 0;
    fc = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        v = elem_store[r * STORE_COLS + c];
        ok = 1'b1;
        for (int k = 0; k < cols; k++) begin
          o = elem_store[r * STORE_COLS + k];
          if (k != c && ((kind == msp_pkg::KIND_ROW_MIN) ? (o <= v) : (o >= v))) ok = 1'b0;
        end
        for (int k = 0; k < rows; k++) begin
          o = elem_store[k * STORE_COLS + c];
          if (k != r && ((kind == msp_pkg::KIND_ROW_MIN) ? (o >= v) : (o <= v))) ok = 1'b0;
        end
        if (ok) begin
          fr = r;
          fc = c;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_element(input logic signed [31:0] value);
    int rows;
    int cols;
    int pos;
    int fr;
    int fc;
    int hits;
    logic kind;
    msp_pkg::res_t pair [2];
    rows = eff_size(rows_cfg);
    cols = eff_size(cols_cfg);
    pos = load_pos;
    if (pos >= rows * cols) pos = 0;
    elem_store[(pos / cols) * STORE_COLS + pos % cols] = value;
    if (pos + 1 < rows * cols) begin
      load_pos = pos + 1;
      return;
    end
    load_pos = 0;
    hits = 0;
    for (int k = 0; k < 2; k++) begin
      kind = (k == 0) ? msp_pkg::KIND_ROW_MIN : msp_pkg::KIND_ROW_MAX;
      if (find_saddle(rows, cols, kind, fr, fc)) begin
        pair[hits] = '0;
        pair[hits].found = 1'b1;
        pair[hits].value = elem_store[fr * STORE_COLS + fc];
        pair[hits].row = fr[3:0];
        pair[hits].col = fc[3:0];
        pair[hits].kind = kind;
        hits++;
      end
    end
    if (hits == 0) begin
      pair[0] = '0;
      pair[0].last = 1'b1;
      saddle_q.push_back(pair[0]);
    end else begin
      pair[hits - 1].last = 1'b1;
      for (int k = 0; k < hits; k++) saddle_q.push_back(pair[k]);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_result();
    msp_pkg::res_t want;
    if (saddle_q.size() == 0) begin
      report_mismatch("result with none pending", $signed(out_tdata[32:1]), 0);
      return;
    end
    want = saddle_q.pop_front();
    if (out_tdata[0] !== want.found) report_mismatch("found", out_tdata[0], want.found);
    if (out_tdata[32:1] !== want.value)
      report_mismatch("saddle_value", $signed(out_tdata[32:1]), want.value);
    if (out_tdata[36:33] !== want.row) report_mismatch("row_index", out_tdata[36:33], want.row);
    if (out_tdata[40:37] !== want.col) report_mismatch("col_index", out_tdata[40:37], want.col);
    if (out_tuser !== want.kind) report_mismatch("saddle_kind", out_tuser, want.kind);
    if (out_tlast !== want.last) report_mismatch("last_result", out_tlast, want.last);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  // receiver: short stalls mostly, some long ones, and stretches of steady ready
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (ready_roll < 70) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(20, 80);
      end else if (ready_roll < 93) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("matrix_saddle_point_finder regression: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) in_burst = !in_burst;
    if (in_burst || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_element(input logic [31:0] value);
    int gap;
    in_tdata <= value;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_element(value);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block is idle once every pending result is out and a few cycles have passed
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (saddle_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [4:0] rows_raw, input logic [4:0] cols_raw);
    cfg_we <= 1'b1;
    cfg_addr <= msp_pkg::REG_NUM_ROWS;
    cfg_wdata <= rows_raw;
    @(posedge clk);
    rows_cfg = rows_raw;
    load_pos = 0;
    cfg_addr <= msp_pkg::REG_NUM_COLS;
    cfg_wdata <= cols_raw;
    @(posedge clk);
    cols_cfg = cols_raw;
    load_pos = 0;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [4:0] pick_size_raw();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 5'd0;
    if (roll < 10) return 5'($urandom_range(17, 31));
    if (roll < 15) return 5'd16;
    if (roll < 25) return 5'($urandom_range(5, 8));
    return 5'($urandom_range(1, 4));
  endfunction

  function automatic fill_t pick_fill();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return FILL_SADDLE;
    if (roll < 80) return FILL_NARROW;
    return FILL_WIDE;
  endfunction

  function automatic int spread();
    return 1 + int'($urandom_range(0, 1000));
  endfunction

  // planted kind-0 point, often a kind-1 point too, sometimes spoilt by a tie
  task automatic fill_saddle(input int rows, input int cols);
    int r0;
    int c0;
    int r1;
    int c1;
    int v0;
    int v1;
    int hi;
    int lo;
    bit both;
    r0 = $urandom_range(0, rows - 1);
    c0 = $urandom_range(0, cols - 1);
    both = rows > 1 && cols > 1 && $urandom_range(0, 1) == 1;
    r1 = both ? (r0 + 1 + $urandom_range(0, rows - 2)) % rows : r0;
    c1 = both ? (c0 + 1 + $urandom_range(0, cols - 2)) % cols : c0;
    v0 = int'($urandom_range(0, 2147483647)) - 1073741824;
    v1 = v0 + int'($urandom_range(0, 2000)) - 1000;
    hi = (v0 > v1) ? v0 : v1;
    lo = (v0 < v1) ? v0 : v1;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (r == r0 && c == c0) grid[r][c] = v0;
        else if (both && r == r1 && c == c1) grid[r][c] = v1;
        else if (both && r == r0 && c == c1) grid[r][c] = hi + spread();
        else if (both && r == r1 && c == c0) grid[r][c] = lo - spread();
        else if (r == r0) grid[r][c] = v0 + spread();
        else if (c == c0) grid[r][c] = v0 - spread();
        else if (both && r == r1) grid[r][c] = v1 - spread();
        else if (both && c == c1) grid[r][c] = v1 + spread();
        else grid[r][c] = v0 + int'($urandom_range(0, 6000)) - 3000;
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      if (cols > 1) grid[r0][(c0 + 1) % cols] = v0;
      else if (rows > 1) grid[(r0 + 1) % rows][c0] = v0;
    end
  endtask

  task automatic send_matrix(input fill_t fill);
    int rows;
    int cols;
    rows = eff_size(rows_cfg);
    cols = eff_size(cols_cfg);
    if (fill == FILL_SADDLE) fill_saddle(rows, cols);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (fill == FILL_NARROW) begin
          grid[r][c] = int'($urandom_range(0, 4)) - 2;
        end else if (fill == FILL_WIDE) begin
          case ($urandom_range(0, 7))
            0: grid[r][c] = 32'h8000_0000;
            1: grid[r][c] = 32'h7FFF_FFFF;
            2: grid[r][c] = -1;
            3: grid[r][c] = 0;
            default: grid[r][c] = $urandom;
          endcase
        end
      end
    end
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        send_element(grid[r][c]);
  endtask

  // no write yet, so the matrix is 16 by 16
  task automatic test_reset_size();
    send_matrix(FILL_SADDLE);
    wait_results_done();
  endtask

  // 1x1 reports its element as both kinds
  task automatic test_single_element();
    write_sizes(5'd1, 5'd1);
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    wait_results_done();
  endtask

  // one row or one column: the missing direction holds trivially; a tie gives none
  task automatic test_single_line();
    write_sizes(5'd0, 5'd3);
    send_element(32'd5);
    send_element(-32'sd7);
    send_element(32'd9);
    wait_results_done();
    write_sizes(5'd1, 5'd2);
    send_element(32'd3);
    send_element(32'd3);
    wait_results_done();
    write_sizes(5'd3, 5'd0);
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    wait_results_done();
  endtask

  task automatic test_extremes();
    write_sizes(5'd2, 5'd2);
    send_element(-32'sd1);
    send_element(32'h7FFF_FFFF);
    send_element(32'h8000_0000);
    send_element(32'h0000_0000);
    wait_results_done();
  endtask

  // a size write part way through a matrix drops what was loaded
  task automatic test_dropped_load();
    write_sizes(5'd2, 5'd2);
    send_element(32'hFFFF_FFFF);
    send_element(32'h5555_5555);
    wait_results_done();
    write_sizes(5'd31, 5'd0);
    send_matrix(FILL_WIDE);
    wait_results_done();
  endtask

  task automatic test_random();
    int start;
    int rows;
    int cols;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_results_done();
      write_sizes(pick_size_raw(), pick_size_raw());
      rows = eff_size(rows_cfg);
      cols = eff_size(cols_cfg);
      if (rows * cols > 1 && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, rows * cols - 1);
        repeat (n) send_element($urandom);
        continue;
      end
      repeat ($urandom_range(1, 4)) send_matrix(pick_fill());
    end
    wait_results_done();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_single_element();
    test_single_line();
    test_extremes();
    test_dropped_load();
    test_random();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("matrix_saddle_point_finder regression: pass");
    end else begin
      $display("matrix_saddle_point_finder regression: fail");
    end
    $finish;
  end

endmodule
